[hw/rtl/sot_pkg.sv]
// ----------------------------------------------------------------------------
// sot_pkg
// Shared constants and types of the sorted order table.
// ----------------------------------------------------------------------------
package sot_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int TOT_W    = 24;
    localparam int RANK_W   = 5;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_EMPTY_RANGE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TOT_W-1:0] total;
    } entry_t;

endpackage

[hw/rtl/sorted_order_table.sv]
// ----------------------------------------------------------------------------
// sorted_order_table
// Bounded table of (id, total) records kept in descending order of total,
// held in one synchronous memory and walked one entry per cycle.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                    tuser
// s_axis   in   order_id, order_total, rank, pad[3]   req_type
// m_axis   out  status, entry_id, entry_total, count  -
//
// One item at a time. Delete and insert run at one memory read per cycle
// as the walk visits each record; insert walks from the tail, delete
// from the head.
// Reset clears the count and control; the memory keeps no reset.
// A stalled result holds in the output register; the next item is taken
// meanwhile and its result waits until the output register frees.
// ----------------------------------------------------------------------------
module sorted_order_table
    import sot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // order_id[15:0], order_total[39:16], rank[44:40]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], entry_id[17:2], entry_total[41:18],
                                   // entry_count[47:42]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    entry_t mem [CAPACITY];

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              found_reg, found_next;
    logic [ID_W-1:0]   req_id_reg, req_id_next;
    logic [TOT_W-1:0]  req_tot_reg, req_tot_next;
    logic [1:0]        sts_reg, sts_next;
    entry_t            res_reg, res_next;
    logic              mv_reg, mv_next;
    logic [47:0]       md_reg, md_next;

    entry_t            rdata_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic [1:0]        in_type;
    logic [ID_W-1:0]   in_id;
    logic [TOT_W-1:0]  in_tot;
    logic [RANK_W-1:0] in_rank;
    logic              in_acc;
    logic              last_ent;

    assign in_id    = s_tdata[15:0];
    assign in_tot   = s_tdata[39:16];
    assign in_rank  = s_tdata[44:40];
    assign in_type  = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign last_ent = ({1'b0, ridx_reg} == (cnt_reg - CNT_W'(1)));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        left_next    = left_reg;
        pend_next    = 1'b0;
        ridx_next    = ridx_reg;
        found_next   = found_reg;
        req_id_next  = req_id_reg;
        req_tot_next = req_tot_reg;
        sts_next     = sts_reg;
        res_next     = res_reg;
        mv_next      = mv_reg;
        md_next      = md_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg;
        wr_data      = rdata_reg;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_id_next  = in_id;
                    req_tot_next = in_tot;
                    sts_next     = ST_OK;
                    res_next     = '0;
                    found_next   = 1'b0;
                    state_next   = S_DONE;
                    case (in_type)
                        REQ_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(CAPACITY))
                            begin
                                sts_next = ST_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = '0;
                                wr_data  = '{id: in_id, total: in_tot};
                                cnt_next = CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(cnt_reg - CNT_W'(1));
                                left_next  = cnt_reg;
                                state_next = S_INS;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                sts_next = ST_EMPTY_RANGE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                left_next  = cnt_reg;
                                state_next = S_DEL;
                            end
                        end
                        REQ_READ:
                        begin
                            if (CNT_W'(in_rank) < cnt_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(in_rank);
                                state_next = S_RD;
                            end
                            else
                            begin
                                sts_next = ST_EMPTY_RANGE;
                            end
                        end
                        default:
                        begin
                            sts_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    ptr_next  = ptr_reg - IDX_W'(1);
                    left_next = left_reg - CNT_W'(1);
                    pend_next = 1'b1;
                    ridx_next = ptr_reg;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ridx_reg + IDX_W'(1);
                    if (rdata_reg.total > req_tot_reg)
                    begin
                        wr_data    = '{id: req_id_reg, total: req_tot_reg};
                        cnt_next   = cnt_reg + CNT_W'(1);
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (ridx_reg == '0)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{id: req_id_reg, total: req_tot_reg};
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DEL:
            begin
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    ptr_next  = ptr_reg + IDX_W'(1);
                    left_next = left_reg - CNT_W'(1);
                    pend_next = 1'b1;
                    ridx_next = ptr_reg;
                end
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ridx_reg - IDX_W'(1);
                    end
                    else if (rdata_reg.id == req_id_reg)
                    begin
                        found_next = 1'b1;
                    end
                    if (last_ent)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                        if (found_reg || (rdata_reg.id == req_id_reg))
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        else
                        begin
                            sts_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_RD:
            begin
                res_next   = rdata_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {cnt_reg, res_reg.total, res_reg.id, sts_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        left_reg    <= left_next;
        ridx_reg    <= ridx_next;
        req_id_reg  <= req_id_next;
        req_tot_reg <= req_tot_next;
        sts_reg     <= sts_next;
        res_reg     <= res_next;
        md_reg      <= md_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("record count above capacity");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("walk reads the entry it writes");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && (md_reg[1:0] == ST_FULL)) |-> (md_reg[47:42] == CNT_W'(CAPACITY)))
        else $error("full status with spare room");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == CNT_W'(1)))
        else $error("count moved outside a walk");

endmodule
